// ===== hdl/batching_wait_queue_with_timeout_assert.svh =====
// ----------------------------------------------------------------------------
// Batching wait queue with timeout: assertion macros
// Concurrent assertion wrappers clocked on clk_i. They are empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef BATCHING_WAIT_QUEUE_WITH_TIMEOUT_ASSERT_SVH
`define BATCHING_WAIT_QUEUE_WITH_TIMEOUT_ASSERT_SVH
`ifndef SYNTHESIS
`define BWQT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BWQT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define BWQT_ASSERT(lbl, prop, msg)
`define BWQT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/bwqt_pkg.sv =====
// ----------------------------------------------------------------------------
// Batching wait queue with timeout: package
// Shared codes, constants and the words passed between the blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bwqt_pkg;

  localparam int BATCH_W = 5;
  localparam int AGE_W   = 16;
  localparam int OID_W   = 8;
  localparam int SEAT_W  = 4;

  localparam logic [BATCH_W-1:0] BATCH_CAP = 5'd16;

  localparam logic [1:0] CMD_JOIN  = 2'd0;
  localparam logic [1:0] CMD_LEAVE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  typedef enum logic [1:0] {
    OP_JOIN  = 2'd0,
    OP_LEAVE = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KIND_JOINED    = 3'd0,
    KIND_DUPLICATE = 3'd1,
    KIND_FULL      = 3'd2,
    KIND_LEFT      = 3'd3,
    KIND_ABSENT    = 3'd4,
    KIND_RELEASED  = 3'd5
  } kind_e;

  typedef struct packed {
    op_e              op;
    logic [OID_W-1:0] id;
  } q_word_t;

  typedef struct packed {
    logic [BATCH_W-1:0] max_batch;
    logic [BATCH_W-1:0] min_batch;
    logic [AGE_W-1:0]   timeout_ticks;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [OID_W-1:0]  id;
    logic [SEAT_W-1:0] seat;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/batching_wait_queue_with_timeout.sv =====
// ----------------------------------------------------------------------------
// Batching wait queue with timeout
// Ordered wait queue of member ids that releases batches on size or age.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i, in_stall_o  command_i, member_id_i
//   out      output     out_valid_o, out_stall_i kind_o, member_id_res_o, seat_o, last_o
//   cfg      input      psel, penable, pready   paddr, pwdata, pwrite, prdata
//
// A join, or a leave that misses, reads the stored ids in turn up to a match or the end.
// A leave that finds its id then moves the entries behind it up before its result word.
// A releasing tick reads out each released id, then moves the remaining entries up;
// any other tick at most updates the age. The store's single read port sets this pace.
// Reset clears the counters, state and valid flags; the id store needs no clearing pass.
// A stalled result holds the engine; the front takes words until its two-entry queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "batching_wait_queue_with_timeout_assert.svh"

module batching_wait_queue_with_timeout #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  member_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  member_id_res_o,
  output logic [3:0]  seat_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_MAX_BATCH = 2'd0;
  localparam logic [1:0] REG_MIN_BATCH = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;

  logic [bwqt_pkg::BATCH_W-1:0] max_batch_q, min_batch_q;
  logic [bwqt_pkg::AGE_W-1:0]   timeout_q;
  bwqt_pkg::cfg_t               cfg;
  bwqt_pkg::q_word_t            q_word;
  bwqt_pkg::res_t               res;
  logic                         q_valid, q_pop, cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_batch_q <= 5'd4;
      min_batch_q <= 5'd2;
      timeout_q   <= 16'd100;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MAX_BATCH: max_batch_q <= pwdata[bwqt_pkg::BATCH_W-1:0];
        REG_MIN_BATCH: min_batch_q <= pwdata[bwqt_pkg::BATCH_W-1:0];
        REG_TIMEOUT:   timeout_q   <= pwdata[bwqt_pkg::AGE_W-1:0];
        default:       timeout_q   <= timeout_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_BATCH: prdata = 32'(max_batch_q);
      REG_MIN_BATCH: prdata = 32'(min_batch_q);
      REG_TIMEOUT:   prdata = 32'(timeout_q);
      default:       prdata = '0;
    endcase
  end

  assign cfg.max_batch     = max_batch_q;
  assign cfg.min_batch     = min_batch_q;
  assign cfg.timeout_ticks = timeout_q;

  bwqt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .member_id_i (member_id_i),
    .q_valid_o   (q_valid),
    .q_word_o    (q_word),
    .q_pop_i     (q_pop)
  );

  bwqt_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_word_i    (q_word),
    .q_pop_o     (q_pop),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign kind_o          = res.kind;
  assign member_id_res_o = res.id;
  assign seat_o          = res.seat;
  assign last_o          = res.last;

  `BWQT_ASSERT(a_single_shape, out_valid_o && (kind_o != bwqt_pkg::KIND_RELEASED) |-> last_o && (seat_o == 4'd0), "Non-release word must be last with seat zero.")
  `BWQT_ASSERT(a_seat_step, out_valid_o && !out_stall_i && (kind_o == bwqt_pkg::KIND_RELEASED) && !last_o |=> (kind_o == bwqt_pkg::KIND_RELEASED) && (!out_valid_o || (seat_o == $past(seat_o) + 4'd1)), "Released seats must follow in order.")
  `BWQT_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "No result word may follow reset at once.")

endmodule

`default_nettype wire

// ===== hdl/bwqt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bwqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/bwqt_front.sv =====
// ----------------------------------------------------------------------------
// Batching wait queue with timeout: front end
// Takes input words, decodes the command and queues known ones for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bwqt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        command_i,
  input  logic [7:0]        member_id_i,
  output logic              q_valid_o,
  output bwqt_pkg::q_word_t q_word_o,
  input  logic              q_pop_i
);

  bwqt_pkg::q_word_t fifo_q [2];
  bwqt_pkg::q_word_t word;
  logic              known;
  logic              push;
  logic              wr_q, rd_q;
  logic [1:0]        cnt_q, cnt_d;

  always_comb begin
    word.id = member_id_i;
    word.op = bwqt_pkg::OP_TICK;
    known   = 1'b1;
    unique case (command_i)
      bwqt_pkg::CMD_JOIN:  word.op = bwqt_pkg::OP_JOIN;
      bwqt_pkg::CMD_LEAVE: word.op = bwqt_pkg::OP_LEAVE;
      bwqt_pkg::CMD_TICK:  word.op = bwqt_pkg::OP_TICK;
      default:             known   = 1'b0;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o && known;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_word_o   = fifo_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (q_pop_i) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= word;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bwqt_engine.sv =====
// ----------------------------------------------------------------------------
// Batching wait queue with timeout: engine
// Walks the id store one entry per cycle to search, compact and release; a stalled result holds a release.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bwqt_engine #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  bwqt_pkg::q_word_t q_word_i,
  output logic              q_pop_o,
  input  bwqt_pkg::cfg_t    cfg_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bwqt_pkg::res_t    res_o
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int XW = (CW > bwqt_pkg::BATCH_W) ? CW : bwqt_pkg::BATCH_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE        = CW'(1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_COMPACT = 3'd2;
  localparam logic [2:0] ST_RELEASE = 3'd3;
  localparam logic [2:0] ST_EMIT    = 3'd4;

  logic [2:0]                  state_q, state_d;
  bwqt_pkg::op_e               op_q, op_d;
  bwqt_pkg::kind_e             kind_q, kind_d;
  logic [ID_BITS-1:0]          id_q, id_d;
  logic [CW-1:0]               count_q, count_d;
  logic [CW-1:0]               ptr_q, ptr_d;
  logic [CW-1:0]               wptr_q, wptr_d;
  logic [CW-1:0]               nrel_q, nrel_d;
  logic [bwqt_pkg::AGE_W-1:0]  age_q, age_d, age_inc;
  logic                        vld_q, vld_d;
  logic                        out_valid_q, out_valid_d;
  bwqt_pkg::res_t              out_q, out_d;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr;
  logic [ID_BITS-1:0]          ram_wdata, ram_rdata;

  logic [bwqt_pkg::BATCH_W-1:0] cap_b;
  logic [XW-1:0]                cap_x, cnt_x, min_x;
  logic                         rel_full, rel_timed;
  logic                         id_match, ov_free, issue, consume, rel_last;

  bwqt_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign cap_b = (cfg_i.max_batch == '0) ? 5'd1 :
                 (cfg_i.max_batch > bwqt_pkg::BATCH_CAP) ? bwqt_pkg::BATCH_CAP :
                 cfg_i.max_batch;
  assign cap_x     = XW'(cap_b);
  assign cnt_x     = XW'(count_q);
  assign min_x     = XW'(cfg_i.min_batch);
  assign age_inc   = (age_q == '1) ? age_q : age_q + 16'd1;
  assign rel_full  = (cnt_x >= cap_x);
  assign rel_timed = (cnt_x >= min_x) && (age_inc >= cfg_i.timeout_ticks);
  assign id_match  = (ram_rdata == id_q);
  assign ov_free   = !out_valid_q || !out_stall_i;
  assign rel_last  = ((wptr_q + ONE) == nrel_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    kind_d      = kind_q;
    id_d        = id_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    wptr_d      = wptr_q;
    nrel_d      = nrel_q;
    age_d       = age_q;
    vld_d       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = wptr_q[AW-1:0];
    ram_wdata   = ram_rdata;
    issue       = 1'b0;
    consume     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          op_d    = q_word_i.op;
          id_d    = ID_BITS'(q_word_i.id);
          ptr_d   = '0;
          wptr_d  = '0;
          unique case (q_word_i.op)
            bwqt_pkg::OP_JOIN, bwqt_pkg::OP_LEAVE: state_d = ST_SCAN;
            bwqt_pkg::OP_TICK: begin
              if (count_q != '0) begin
                if (rel_full || rel_timed) begin
                  age_d   = '0;
                  nrel_d  = rel_full ? CW'(cap_x) : count_q;
                  state_d = ST_RELEASE;
                end else begin
                  age_d = age_inc;
                end
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (vld_q && id_match) begin
          if (op_q == bwqt_pkg::OP_JOIN) begin
            kind_d  = bwqt_pkg::KIND_DUPLICATE;
            state_d = ST_EMIT;
          end else begin
            kind_d  = bwqt_pkg::KIND_LEFT;
            nrel_d  = ONE;
            wptr_d  = wptr_q;
            ptr_d   = wptr_q + ONE;
            state_d = ST_COMPACT;
          end
        end else begin
          issue = (ptr_q < count_q);
          if (issue) begin
            ram_re = 1'b1;
            ptr_d  = ptr_q + ONE;
          end
          vld_d = issue;
          if (vld_q) begin
            wptr_d = wptr_q + ONE;
          end
          if (!vld_q && !issue) begin
            if (op_q == bwqt_pkg::OP_JOIN) begin
              if (count_q == FULL_COUNT) begin
                kind_d = bwqt_pkg::KIND_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                ram_wdata = id_q;
                count_d   = count_q + ONE;
                kind_d    = bwqt_pkg::KIND_JOINED;
                if (count_q == '0) begin
                  age_d = '0;
                end
              end
            end else begin
              kind_d = bwqt_pkg::KIND_ABSENT;
            end
            state_d = ST_EMIT;
          end
        end
      end
      ST_COMPACT: begin
        issue = (ptr_q < count_q);
        if (issue) begin
          ram_re = 1'b1;
          ptr_d  = ptr_q + ONE;
        end
        vld_d = issue;
        if (vld_q) begin
          ram_we = 1'b1;
          wptr_d = wptr_q + ONE;
        end
        if (!vld_q && !issue) begin
          count_d = count_q - nrel_q;
          state_d = (op_q == bwqt_pkg::OP_LEAVE) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_RELEASE: begin
        consume = vld_q && ov_free;
        issue   = (ptr_q < nrel_q) && (!vld_q || consume);
        if (issue) begin
          ram_re = 1'b1;
          ptr_d  = ptr_q + ONE;
        end
        vld_d = issue || (vld_q && !consume);
        if (consume) begin
          out_valid_d = 1'b1;
          out_d.kind  = bwqt_pkg::KIND_RELEASED;
          out_d.id    = bwqt_pkg::OID_W'(ram_rdata);
          out_d.seat  = bwqt_pkg::SEAT_W'(wptr_q);
          out_d.last  = rel_last;
          wptr_d      = wptr_q + ONE;
          if (rel_last) begin
            ptr_d   = nrel_q;
            wptr_d  = '0;
            vld_d   = 1'b0;
            state_d = ST_COMPACT;
          end
        end
      end
      ST_EMIT: begin
        if (ov_free) begin
          out_valid_d = 1'b1;
          out_d.kind  = kind_q;
          out_d.id    = bwqt_pkg::OID_W'(id_q);
          out_d.seat  = '0;
          out_d.last  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      age_q       <= '0;
      vld_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      age_q       <= age_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    kind_q <= kind_d;
    id_q   <= id_d;
    ptr_q  <= ptr_d;
    wptr_q <= wptr_d;
    nrel_q <= nrel_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

// ===== bench/batching_wait_queue_with_timeout_tb.sv =====
// ----------------------------------------------------------------------------
// Batching wait queue with timeout: testbench
// Drives join, leave and tick words through the input channel and checks each
// result word against a queue model kept in step with every accepted word.
// Covers duplicate and full joins, leaves that close gaps, size and timeout
// releases, and register limits, then runs random traffic under several
// register settings, with random stalls on both sides in all but one phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module batching_wait_queue_with_timeout_tb;

  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  localparam int         REG_MAX_BATCH = 0;
  localparam int         REG_MIN_BATCH = 1;
  localparam int         REG_TIMEOUT   = 2;
  localparam int         SEATS         = 16;
  localparam int         SETTLE_CYCLES = 40;
  localparam logic [bwqt_pkg::AGE_W-1:0] AGE_LIMIT = '1;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic [1:0]                  command_i   = '0;
  logic [bwqt_pkg::OID_W-1:0]  member_id_i = '0;
  logic                        out_stall_i = 1'b0;
  logic                        psel        = 1'b0;
  logic                        penable     = 1'b0;
  logic                        pwrite      = 1'b0;
  logic [3:0]                  paddr       = '0;
  logic [31:0]                 pwdata      = '0;
  logic                        in_stall_o;
  logic                        out_valid_o;
  logic [2:0]                  kind_o;
  logic [bwqt_pkg::OID_W-1:0]  member_id_res_o;
  logic [bwqt_pkg::SEAT_W-1:0] seat_o;
  logic                        last_o;
  logic [31:0]                 prdata;
  logic                        pready;

  batching_wait_queue_with_timeout u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .member_id_i     (member_id_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .member_id_res_o (member_id_res_o),
    .seat_o          (seat_o),
    .last_o          (last_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  logic [bwqt_pkg::OID_W-1:0]   waiting_ids [$];
  logic [bwqt_pkg::AGE_W-1:0]   wait_age;
  logic [bwqt_pkg::BATCH_W-1:0] cfg_max_batch;
  logic [bwqt_pkg::BATCH_W-1:0] cfg_min_batch;
  logic [bwqt_pkg::AGE_W-1:0]   cfg_timeout;
  bwqt_pkg::res_t               due_events [$];
  int                           mismatches;
  bit                           quiet;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("batching_wait_queue_with_timeout_tb: errors");
    $finish;
  end

  function automatic void push_event(bwqt_pkg::kind_e kind, logic [bwqt_pkg::OID_W-1:0] id,
                                     logic [bwqt_pkg::SEAT_W-1:0] seat, logic last);
    bwqt_pkg::res_t r;
    r.kind = kind;
    r.id   = id;
    r.seat = seat;
    r.last = last;
    due_events.insert(due_events.size(), r);
  endfunction

  function automatic void track_command(logic [1:0] cmd, logic [bwqt_pkg::OID_W-1:0] id);
    int pos;
    int cap;
    int n;
    pos = -1;
    for (int i = 0; i < waiting_ids.size(); i++)
      if (pos < 0 && waiting_ids[i] == id) pos = i;
    case (cmd)
      bwqt_pkg::CMD_JOIN: begin
        if (pos >= 0) begin
          push_event(bwqt_pkg::KIND_DUPLICATE, id, '0, 1'b1);
        end else if (waiting_ids.size() >= SEATS) begin
          push_event(bwqt_pkg::KIND_FULL, id, '0, 1'b1);
        end else begin
          if (waiting_ids.size() == 0) wait_age = '0;
          waiting_ids.insert(waiting_ids.size(), id);
          push_event(bwqt_pkg::KIND_JOINED, id, '0, 1'b1);
        end
      end
      bwqt_pkg::CMD_LEAVE: begin
        if (pos < 0) begin
          push_event(bwqt_pkg::KIND_ABSENT, id, '0, 1'b1);
        end else begin
          waiting_ids.delete(pos);
          push_event(bwqt_pkg::KIND_LEFT, id, '0, 1'b1);
        end
      end
      bwqt_pkg::CMD_TICK: begin
        if (waiting_ids.size() != 0) begin
          if (wait_age != AGE_LIMIT) wait_age = wait_age + 1'b1;
          if (cfg_max_batch == '0) cap = 1;
          else if (cfg_max_batch > bwqt_pkg::BATCH_CAP) cap = bwqt_pkg::BATCH_CAP;
          else cap = cfg_max_batch;
          if (waiting_ids.size() >= cap ||
              (waiting_ids.size() >= cfg_min_batch && wait_age >= cfg_timeout)) begin
            n = (waiting_ids.size() < cap) ? waiting_ids.size() : cap;
            for (int s = 0; s < n; s++)
              push_event(bwqt_pkg::KIND_RELEASED, waiting_ids.pop_front(),
                         bwqt_pkg::SEAT_W'(s), s == n - 1);
            wait_age = '0;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic [bwqt_pkg::OID_W-1:0] id);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 20) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    command_i   = cmd;
    member_id_i = id;
    do @(posedge clk_i); while (in_stall_o);
    track_command(cmd, id);
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (due_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic write, input logic [3:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic program_register(input int idx, input logic [bwqt_pkg::AGE_W-1:0] value);
    logic [31:0] mask;
    logic [31:0] wdata;
    logic [31:0] rdata;
    mask  = (idx == REG_TIMEOUT) ? 32'h0000_FFFF : 32'h0000_001F;
    wdata = ($urandom & ~mask) | (32'(value) & mask);
    apb_access(1'b1, 4'(idx * 4), wdata, rdata);
    case (idx)
      REG_MAX_BATCH: cfg_max_batch = wdata[bwqt_pkg::BATCH_W-1:0];
      REG_MIN_BATCH: cfg_min_batch = wdata[bwqt_pkg::BATCH_W-1:0];
      default:       cfg_timeout   = wdata[bwqt_pkg::AGE_W-1:0];
    endcase
    apb_access(1'b0, 4'(idx * 4), '0, rdata);
    if (rdata !== (wdata & mask)) begin
      $error("register %0d: expected %0h, actual %0h", idx, wdata & mask, rdata);
      mismatches++;
    end
  endtask

  task automatic configure(input logic [bwqt_pkg::BATCH_W-1:0] max_b,
                           input logic [bwqt_pkg::BATCH_W-1:0] min_b,
                           input logic [bwqt_pkg::AGE_W-1:0] timeout);
    program_register(REG_MAX_BATCH, bwqt_pkg::AGE_W'(max_b));
    program_register(REG_MIN_BATCH, bwqt_pkg::AGE_W'(min_b));
    program_register(REG_TIMEOUT, timeout);
  endtask

  task automatic test_basic_ops;
    send_word(bwqt_pkg::CMD_TICK, 8'h00);
    send_word(CMD_UNUSED, 8'hFF);
    send_word(bwqt_pkg::CMD_LEAVE, 8'h00);
    send_word(bwqt_pkg::CMD_JOIN, 8'h00);
    send_word(bwqt_pkg::CMD_JOIN, 8'hFF);
    send_word(bwqt_pkg::CMD_JOIN, 8'hA5);
    send_word(bwqt_pkg::CMD_JOIN, 8'hFF);
    send_word(bwqt_pkg::CMD_LEAVE, 8'hFF);
    send_word(bwqt_pkg::CMD_JOIN, 8'h5A);
    send_word(bwqt_pkg::CMD_TICK, 8'h00);
    send_word(bwqt_pkg::CMD_JOIN, 8'h3C);
    send_word(bwqt_pkg::CMD_TICK, 8'hFF);
    drain;
  endtask

  task automatic test_batch_limits;
    configure(5'd0, 5'd0, 16'd0);
    send_word(bwqt_pkg::CMD_JOIN, 8'h81);
    send_word(bwqt_pkg::CMD_JOIN, 8'h7E);
    send_word(bwqt_pkg::CMD_TICK, 8'h00);
    send_word(bwqt_pkg::CMD_TICK, 8'h00);
    drain;
    configure(5'd16, 5'd2, 16'd3);
    send_word(bwqt_pkg::CMD_JOIN, 8'h11);
    repeat (3) send_word(bwqt_pkg::CMD_TICK, 8'h00);
    send_word(bwqt_pkg::CMD_JOIN, 8'h22);
    send_word(bwqt_pkg::CMD_TICK, 8'h00);
    drain;
  endtask

  task automatic test_full_queue;
    configure(5'd31, 5'd16, 16'hFFFF);
    for (int i = 0; i < SEATS; i++) send_word(bwqt_pkg::CMD_JOIN, bwqt_pkg::OID_W'(i * 17));
    send_word(bwqt_pkg::CMD_JOIN, 8'h01);
    send_word(bwqt_pkg::CMD_LEAVE, 8'h11);
    send_word(bwqt_pkg::CMD_JOIN, 8'h01);
    send_word(bwqt_pkg::CMD_JOIN, 8'hEE);
    send_word(bwqt_pkg::CMD_TICK, 8'h00);
    drain;
  endtask

  task automatic test_random_traffic;
    logic [bwqt_pkg::OID_W-1:0] id_pool [$];
    logic [bwqt_pkg::OID_W-1:0] id;
    logic [1:0]                 cmd;
    int                         pick;
    for (int phase = 0; phase < 5; phase++) begin
      drain;
      case (phase)
        0: configure(5'($urandom_range(1, 6)), 5'($urandom_range(1, 4)),
                     16'($urandom_range(0, 6)));
        1: configure(5'($urandom_range(17, 31)), 5'd0, 16'($urandom_range(0, 3)));
        2: configure(5'd0, 5'($urandom_range(16, 31)), 16'hFFFF);
        3: configure(5'd16, 5'($urandom_range(1, 16)), 16'($urandom_range(1, 40)));
        default: configure(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                           16'($urandom_range(0, 12)));
      endcase
      quiet = (phase == 1);
      id_pool.delete();
      repeat ($urandom_range(4, 20))
        id_pool.insert(id_pool.size(), bwqt_pkg::OID_W'($urandom));
      repeat (50) begin
        pick = $urandom_range(99);
        if (pick < 45) cmd = bwqt_pkg::CMD_JOIN;
        else if (pick < 68) cmd = bwqt_pkg::CMD_LEAVE;
        else if (pick < 95) cmd = bwqt_pkg::CMD_TICK;
        else cmd = CMD_UNUSED;
        if ($urandom_range(99) < 85) id = id_pool[$urandom_range(id_pool.size() - 1)];
        else id = bwqt_pkg::OID_W'($urandom);
        send_word(cmd, id);
      end
    end
    quiet = 1'b0;
    drain;
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 20);
  end

  always @(posedge clk_i) begin : check_results
    bwqt_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_events.size() == 0) begin
        $error("unexpected word: kind %0d, member_id_res %0h, seat %0d, last %0b",
               kind_o, member_id_res_o, seat_o, last_o);
        mismatches++;
      end else begin
        want = due_events.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, kind_o);
          mismatches++;
        end
        if (member_id_res_o !== want.id) begin
          $error("member_id_res: expected %0h, actual %0h", want.id, member_id_res_o);
          mismatches++;
        end
        if (seat_o !== want.seat) begin
          $error("seat: expected %0d, actual %0d", want.seat, seat_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    waiting_ids.delete();
    due_events.delete();
    wait_age      = '0;
    cfg_max_batch = 5'd4;
    cfg_min_batch = 5'd2;
    cfg_timeout   = 16'd100;
    mismatches    = 0;
    quiet         = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_basic_ops;
    test_batch_limits;
    test_full_queue;
    test_random_traffic;
    if (mismatches == 0) begin
      $display("batching_wait_queue_with_timeout_tb: clean");
    end else begin
      $display("batching_wait_queue_with_timeout_tb: errors");
    end
    $finish;
  end

endmodule
